// ----- rtl/segment_convex_brush_clip_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the brush clip block.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_CONVEX_BRUSH_CLIP_MACROS_SVH
`define SEGMENT_CONVEX_BRUSH_CLIP_MACROS_SVH
// implication checked every clock, skipped in reset
`define SCBC_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define SCBC_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ----- rtl/scbc_pkg.sv -----
// ----------------------------------------------------------------------------
// Brush clip package
// Types shared by the front end, queue and back end.
// ----------------------------------------------------------------------------
package scbc_pkg;
    localparam int DistW = 64;
    localparam int IdW   = 16;
    // configuration register indexes with their own storage
    localparam logic [2:0] RegSweep   = 3'd6;
    localparam logic [2:0] RegEpsilon = 3'd7;
    // classified plane word passed from front to back
    typedef struct packed {
        logic                    begin_trace;
        logic                    last_side;
        logic                    ds_pos;
        logic                    de_pos;
        logic signed [DistW-1:0] ds;
        logic signed [DistW-1:0] de;
        logic [IdW-1:0]          plane_id;
    } t_plane_word;
endpackage

// ----- rtl/scbc_front.sv -----
// ----------------------------------------------------------------------------
// Brush clip front end
// Multiply normals by the segment endpoints and form signed plane distances.
// ----------------------------------------------------------------------------
module scbc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_action,
    input  logic signed [17:0]   i_normal_x,
    input  logic signed [17:0]   i_normal_y,
    input  logic signed [17:0]   i_normal_z,
    input  logic signed [31:0]   i_plane_distance,
    input  logic [15:0]          i_plane_id,
    input  logic                 i_last_side,
    input  logic signed [31:0]   i_sx, i_sy, i_sz, i_ex, i_ey, i_ez,
    input  logic [30:0]          i_offset,
    output logic                 o_valid,
    input  logic                 i_ready,
    output scbc_pkg::t_plane_word o_word
);
    // stage 1 holds input, stage 2 products, output register sums
    logic                r_v1, r_v2, r_vo;
    logic                r_act1, r_last1, r_act2, r_last2;
    logic signed [17:0]  r_nx, r_ny, r_nz;
    logic signed [31:0]  r_pd;
    logic [15:0]         r_id1, r_id2;
    logic signed [49:0]  r_p [0:5];
    logic signed [33:0]  r_base;
    scbc_pkg::t_plane_word r_word, n_word;
    logic                adv_o, adv_2, adv_1;
    logic signed [63:0]  ds_sum, de_sum, base_ext;

    assign adv_o   = !r_vo || i_ready;
    assign adv_2   = !r_v2 || adv_o;
    assign adv_1   = !r_v1 || adv_2;
    assign o_ready = adv_1;

    assign base_ext = {{14{r_base[33]}}, r_base, 16'd0};
    assign ds_sum = 64'(r_p[0]) + 64'(r_p[1]) + 64'(r_p[2]) - base_ext;
    assign de_sum = 64'(r_p[3]) + 64'(r_p[4]) + 64'(r_p[5]) - base_ext;

    always_comb begin
        n_word.begin_trace = !r_act2;
        n_word.last_side   = r_last2;
        n_word.ds          = ds_sum;
        n_word.de          = de_sum;
        n_word.ds_pos      = (ds_sum > 0);
        n_word.de_pos      = (de_sum > 0);
        n_word.plane_id    = r_id2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (adv_1) r_v1 <= i_valid;
            if (adv_2) r_v2 <= r_v1;
            if (adv_o) r_vo <= r_v2;
        end
        if (adv_1 && i_valid) begin
            r_act1  <= i_action;
            r_last1 <= i_last_side;
            r_nx    <= i_normal_x;
            r_ny    <= i_normal_y;
            r_nz    <= i_normal_z;
            r_pd    <= i_plane_distance;
            r_id1   <= i_plane_id;
        end
        if (adv_2 && r_v1) begin
            r_act2  <= r_act1;
            r_last2 <= r_last1;
            r_id2   <= r_id1;
            r_p[0]  <= i_sx * r_nx;
            r_p[1]  <= i_sy * r_ny;
            r_p[2]  <= i_sz * r_nz;
            r_p[3]  <= i_ex * r_nx;
            r_p[4]  <= i_ey * r_ny;
            r_p[5]  <= i_ez * r_nz;
            r_base  <= 34'(r_pd) + 34'({1'b0, i_offset});
        end
        if (adv_o && r_v2) r_word <= n_word;
    end

    assign o_valid = r_vo;
    assign o_word  = r_word;
endmodule

// ----- rtl/scbc_queue.sv -----
// ----------------------------------------------------------------------------
// Brush clip queue
// Two-entry FIFO between front and back end.
// ----------------------------------------------------------------------------
module scbc_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  scbc_pkg::t_plane_word i_word,
    output logic                  o_valid,
    input  logic                  i_ready,
    output scbc_pkg::t_plane_word o_word
);
    scbc_pkg::t_plane_word r_mem [0:1];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push = i_valid && o_ready;
    assign pop  = o_valid && i_ready;
    assign o_word = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
        if (push) r_mem[r_wp] <= i_word;
    end
endmodule

// ----- rtl/scbc_back.sv -----
// ----------------------------------------------------------------------------
// Brush clip back end
// Divide for plane fractions, track brush state, fold into the trace result.
// ----------------------------------------------------------------------------
`include "segment_convex_brush_clip_macros.svh"
module scbc_back #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  scbc_pkg::t_plane_word i_word,
    input  logic [15:0]           i_epsilon,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [FRACTION_BITS:0] o_hit_fraction,
    output logic [15:0]           o_hit_plane,
    output logic                  o_starts_out,
    output logic                  o_all_solid,
    output logic                  o_hit_updated
);
    localparam int FW  = FRACTION_BITS + 2;
    localparam int QW  = FRACTION_BITS + 2;
    localparam int CW  = $clog2(QW + 1);
    localparam logic signed [FW-1:0] One    = FW'(1) <<< FRACTION_BITS;
    localparam logic signed [FW-1:0] NegOne = -One;
    localparam logic [QW-1:0] Lim = {1'b0, {(QW-1){1'b1}}};

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state r_state;
    logic signed [FW-1:0] r_enter, r_exit, r_best;
    logic [15:0] r_enter_id, r_best_id, r_id;
    logic r_so, r_eo, r_dis, r_tso, r_tas;
    logic r_last, r_entering, r_neg, r_sat;
    logic [65:0] r_n, r_d, r_r;
    logic [QW-1:0] r_q;
    logic [CW-1:0] r_cnt;
    logic [FRACTION_BITS:0] r_hf;
    logic [15:0] r_hp;
    logic r_hso, r_has, r_hu;

    logic signed [65:0] eps66, num, den;
    logic [65:0] rem_sh, num_mag, den_mag;
    logic [QW-1:0] mag;
    logic signed [FW-1:0] fr_val;
    logic take, fold_ok;
    logic signed [FW-1:0] b_enter;

    assign o_ready = (r_state == S_IDLE);
    assign take    = i_valid && o_ready;
    assign eps66   = 66'({i_epsilon, 16'd0});
    assign den     = 66'(i_word.ds) - 66'(i_word.de);
    assign num     = (i_word.ds > i_word.de) ? 66'(i_word.ds) - eps66
                                             : 66'(i_word.ds) + eps66;
    assign num_mag = num[65] ? 66'(-num) : 66'(num);
    assign den_mag = den[65] ? 66'(-den) : 66'(den);
    assign rem_sh  = {r_r[64:0], 1'b0};
    assign mag     = r_sat ? Lim : r_q;
    assign fr_val  = r_neg ? -FW'(mag) : FW'(mag);
    assign b_enter = r_enter;
    assign fold_ok = r_so && (b_enter < r_exit) && (b_enter > NegOne)
                     && (b_enter < r_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_enter <= NegOne; r_exit <= One; r_enter_id <= '0;
            r_so <= 1'b0; r_eo <= 1'b0; r_dis <= 1'b0;
            r_best <= One; r_best_id <= '0; r_tso <= 1'b1; r_tas <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready) o_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (take) begin
                    r_last <= i_word.last_side;
                    if (i_word.begin_trace) begin
                        r_best <= One; r_best_id <= '0;
                        r_tso <= 1'b1; r_tas <= 1'b0;
                        r_enter <= NegOne; r_exit <= One; r_enter_id <= '0;
                        r_so <= 1'b0; r_eo <= 1'b0; r_dis <= 1'b0;
                    end else if (r_dis) begin
                        if (i_word.last_side) r_state <= S_OUT;
                    end else begin
                        if (i_word.ds_pos) r_so <= 1'b1;
                        if (i_word.de_pos) r_eo <= 1'b1;
                        if (i_word.ds_pos && i_word.de_pos) begin
                            r_dis <= 1'b1;
                            if (i_word.last_side) r_state <= S_OUT;
                        end else if (i_word.ds_pos || i_word.de_pos) begin
                            r_entering <= (i_word.ds > i_word.de);
                            r_neg <= num[65] ^ den[65];
                            r_d   <= den_mag;
                            r_n   <= num_mag;
                            r_r   <= '0;
                            r_q   <= '0;
                            r_sat <= 1'b0;
                            r_id  <= i_word.plane_id;
                            r_cnt <= CW'(0);
                            r_state <= S_DIV;
                        end else if (i_word.last_side) begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_DIV: begin
                    // long division, one quotient bit per cycle on shifted num
                    if (r_cnt == CW'(0)) begin
                        r_sat <= (r_d == '0) || (r_n >= {r_d[64:0], 1'b0});
                        r_r   <= r_n >= r_d ? r_n - r_d : r_n;
                        r_q   <= QW'(r_n >= r_d);
                        r_cnt <= r_cnt + CW'(1);
                    end else if (r_cnt <= CW'(FRACTION_BITS)) begin
                        if (rem_sh >= r_d) begin
                            r_r <= rem_sh - r_d;
                            r_q <= {r_q[QW-2:0], 1'b1};
                        end else begin
                            r_r <= rem_sh;
                            r_q <= {r_q[QW-2:0], 1'b0};
                        end
                        r_cnt <= r_cnt + CW'(1);
                    end else begin
                        if (r_entering) begin
                            if (fr_val > r_enter) begin
                                r_enter <= fr_val; r_enter_id <= r_id;
                            end
                        end else if (fr_val < r_exit) begin
                            r_exit <= fr_val;
                        end
                        r_state <= r_last ? S_OUT : S_IDLE;
                    end
                end
                S_OUT: if (!o_valid) begin
                    r_hso <= r_tso; r_has <= r_tas; r_hu <= 1'b0;
                    r_hf <= r_best[FRACTION_BITS:0]; r_hp <= r_best_id;
                    if (!r_dis) begin
                        if (!r_so) begin
                            r_tso <= 1'b0; r_hso <= 1'b0;
                            if (!r_eo) begin
                                r_tas <= 1'b1; r_has <= 1'b1;
                            end
                        end else if (fold_ok) begin
                            r_best <= b_enter[FW-1] ? '0 : b_enter;
                            r_best_id <= r_enter_id;
                            r_hf <= b_enter[FW-1] ? '0 : b_enter[FRACTION_BITS:0];
                            r_hp <= r_enter_id; r_hu <= 1'b1;
                        end
                    end
                    r_enter <= NegOne; r_exit <= One; r_enter_id <= '0;
                    r_so <= 1'b0; r_eo <= 1'b0; r_dis <= 1'b0;
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_hit_fraction = r_hf;
    assign o_hit_plane    = r_hp;
    assign o_starts_out   = r_hso;
    assign o_all_solid    = r_has;
    assign o_hit_updated  = r_hu;

    `SCBC_ASSERT_IMP(a_upd_hit, i_clk, i_rst_n, o_valid && o_hit_updated,
        o_hit_fraction <= (FRACTION_BITS+1)'(One))
    `SCBC_ASSERT_NXT(a_out_idle, i_clk, i_rst_n, r_state == S_OUT && !o_valid,
        r_state == S_IDLE && o_valid)
    `SCBC_ASSERT_IMP(a_best_range, i_clk, i_rst_n, 1'b1,
        !r_best[FW-1] && r_best <= One)
    `SCBC_ASSERT_IMP(a_solid_in, i_clk, i_rst_n, r_tas, !r_tso)
    `SCBC_ASSERT_IMP(a_state_hot, i_clk, i_rst_n, 1'b1, $onehot(r_state))
endmodule

// ----- rtl/segment_convex_brush_clip.sv -----
// ----------------------------------------------------------------------------
// Segment convex brush clip
// Clips a configured trace segment against convex brushes plane by plane.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready) carries one word per begin action or brush
// plane. Output channel (o_valid/i_ready) carries one word per brush last
// plane with the running nearest hit, starts-out and all-solid flags.
// Front end: three register stages (capture, six products, distance sums),
// one word per cycle while the queue accepts. A two-word queue separates it
// from the back end. Back end: a plane that straddles holds it while it takes
// the word and runs the bit-serial divider (one quotient bit per cycle), then
// folds the fraction; other planes are taken directly, and a last plane
// then folds into the trace result before the word is sent.
// The configuration port writes registers directly; write only while idle.
// Reset clears all trace and brush state; epsilon returns to 2048.
// When the receiver stalls, the finished word holds and the back end waits
// at the next fold; the queue and front end keep filling until full.
// ----------------------------------------------------------------------------
module segment_convex_brush_clip #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [2:0]              i_cfg_index,
    input  logic [31:0]             i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_action,
    input  logic signed [17:0]      i_normal_x,
    input  logic signed [17:0]      i_normal_y,
    input  logic signed [17:0]      i_normal_z,
    input  logic signed [31:0]      i_plane_distance,
    input  logic [15:0]             i_plane_id,
    input  logic                    i_last_side,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [FRACTION_BITS:0]  o_hit_fraction,
    output logic [15:0]             o_hit_plane,
    output logic                    o_starts_out,
    output logic                    o_all_solid,
    output logic                    o_hit_updated
);
    logic signed [31:0] r_reg [0:5];
    logic [30:0] r_offset;
    logic [15:0] r_eps;
    logic f_v, q_r, q_v, b_r;
    scbc_pkg::t_plane_word f_w, q_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) r_reg[k] <= '0;
            r_offset <= '0;
            r_eps    <= 16'd2048;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                scbc_pkg::RegSweep:   r_offset <= i_cfg_data[30:0];
                scbc_pkg::RegEpsilon: r_eps <= i_cfg_data[15:0];
                default: r_reg[i_cfg_index] <= i_cfg_data;
            endcase
        end
    end

    scbc_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_action, .i_normal_x, .i_normal_y, .i_normal_z,
        .i_plane_distance, .i_plane_id, .i_last_side,
        .i_sx(r_reg[0]), .i_sy(r_reg[1]), .i_sz(r_reg[2]),
        .i_ex(r_reg[3]), .i_ey(r_reg[4]), .i_ez(r_reg[5]),
        .i_offset(r_offset),
        .o_valid(f_v), .i_ready(q_r), .o_word(f_w)
    );

    scbc_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(f_v), .o_ready(q_r), .i_word(f_w),
        .o_valid(q_v), .i_ready(b_r), .o_word(q_w)
    );

    scbc_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_v), .o_ready(b_r), .i_word(q_w),
        .i_epsilon(r_eps), .o_valid, .i_ready,
        .o_hit_fraction, .o_hit_plane, .o_starts_out, .o_all_solid, .o_hit_updated
    );
endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Brush clip testbench
// Drives begin actions and brush planes against several segment settings and
// checks every reported hit word against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------

typedef struct {
    logic               action;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic signed [17:0] nz;
    logic signed [31:0] pd;
    logic [15:0]        id;
    logic               last;
} t_tb_word;

typedef struct {
    logic [16:0] frac;
    logic [15:0] plane;
    logic        so;
    logic        solid;
    logic        upd;
} t_hit_word;

typedef enum logic [2:0] {
    REG_START_X, REG_START_Y, REG_START_Z,
    REG_END_X, REG_END_Y, REG_END_Z,
    REG_SWEEP, REG_EPSILON
} t_clip_reg;

localparam logic ACT_BEGIN = 1'b0;
localparam logic ACT_PLANE = 1'b1;
localparam int   FB        = 16;
localparam int   ONE       = 1 << FB;

class clip_scoreboard;
    longint    seg_start[3];
    longint    seg_end[3];
    longint    sweep;
    longint    eps;
    int        best_frac;
    bit [15:0] best_id;
    bit        trace_out;
    bit        trace_solid;
    int        enter_frac;
    int        exit_frac;
    bit [15:0] enter_id;
    bit        start_out;
    bit        end_out;
    bit        dismissed;
    t_hit_word hits_due[$];
    int        errors;

    function new();
        foreach (seg_start[i]) begin
            seg_start[i] = 0;
            seg_end[i] = 0;
        end
        sweep = 0;
        eps = 2048;
        errors = 0;
        clear_trace();
    endfunction

    function void clear_brush();
        enter_frac = -ONE;
        exit_frac = ONE;
        enter_id = 0;
        start_out = 0;
        end_out = 0;
        dismissed = 0;
    endfunction

    function void clear_trace();
        best_frac = ONE;
        best_id = 0;
        trace_out = 1;
        trace_solid = 0;
        clear_brush();
    endfunction

    function void set_reg(t_clip_reg idx, logic [31:0] v);
        case (idx)
            REG_START_X: seg_start[0] = longint'($signed(v));
            REG_START_Y: seg_start[1] = longint'($signed(v));
            REG_START_Z: seg_start[2] = longint'($signed(v));
            REG_END_X:   seg_end[0] = longint'($signed(v));
            REG_END_Y:   seg_end[1] = longint'($signed(v));
            REG_END_Z:   seg_end[2] = longint'($signed(v));
            REG_SWEEP:   sweep = longint'(v[30:0]);
            REG_EPSILON: eps = longint'(v[15:0]);
            default: ;
        endcase
    endfunction

    function int frac_quot(longint num, longint den);
        longint unsigned n, d, lim, mag, r;
        n = (num < 0) ? longint'(-num) : num;
        d = (den < 0) ? longint'(-den) : den;
        lim = (64'd2 << FB) - 1;
        if (d == 0 || n / d >= 2) begin
            mag = lim;
        end else begin
            r = n % d;
            mag = n / d;
            for (int i = 0; i < FB; i++) begin
                r = r << 1;
                mag = mag << 1;
                if (r >= d) begin
                    r = r - d;
                    mag = mag | 1;
                end
            end
            if (mag > lim) mag = lim;
        end
        return ((num < 0) != (den < 0)) ? -int'(mag) : int'(mag);
    endfunction

    function void note_input(t_tb_word w);
        longint    base, ds, de, n[3];
        int        f;
        bit        upd;
        t_hit_word h;
        upd = 0;
        if (w.action == ACT_BEGIN) begin
            clear_trace();
            return;
        end
        if (!dismissed) begin
            n[0] = longint'(w.nx);
            n[1] = longint'(w.ny);
            n[2] = longint'(w.nz);
            base = (longint'(w.pd) + sweep) * 65536;
            ds = -base;
            de = -base;
            for (int i = 0; i < 3; i++) begin
                ds += seg_start[i] * n[i];
                de += seg_end[i] * n[i];
            end
            if (ds > 0) start_out = 1;
            if (de > 0) end_out = 1;
            if (ds > 0 && de > 0) begin
                dismissed = 1;
            end else if (ds > 0 || de > 0) begin
                if (ds > de) begin
                    f = frac_quot(ds - eps * 65536, ds - de);
                    if (f > enter_frac) begin
                        enter_frac = f;
                        enter_id = w.id;
                    end
                end else begin
                    f = frac_quot(ds + eps * 65536, ds - de);
                    if (f < exit_frac) exit_frac = f;
                end
            end
        end
        if (!w.last) return;
        if (!dismissed) begin
            if (!start_out) begin
                trace_out = 0;
                if (!end_out) trace_solid = 1;
            end else if (enter_frac < exit_frac && enter_frac > -ONE &&
                         enter_frac < best_frac) begin
                best_frac = (enter_frac < 0) ? 0 : enter_frac;
                best_id = enter_id;
                upd = 1;
            end
        end
        clear_brush();
        h.frac = best_frac[16:0];
        h.plane = best_id;
        h.so = trace_out;
        h.solid = trace_solid;
        h.upd = upd;
        hits_due = {hits_due, h};
    endfunction

    function void check_hit(t_hit_word a);
        t_hit_word e;
        if (hits_due.size() == 0) begin
            $display("%0t: unexpected hit word frac=%0d plane=%0d", $time, a.frac, a.plane);
            errors++;
            return;
        end
        e = hits_due.pop_front();
        if (a.frac !== e.frac) begin
            $display("%0t: hit_fraction expected %0d actual %0d", $time, e.frac, a.frac);
            errors++;
        end
        if (a.plane !== e.plane) begin
            $display("%0t: hit_plane expected %0d actual %0d", $time, e.plane, a.plane);
            errors++;
        end
        if (a.so !== e.so) begin
            $display("%0t: starts_out expected %0d actual %0d", $time, e.so, a.so);
            errors++;
        end
        if (a.solid !== e.solid) begin
            $display("%0t: all_solid expected %0d actual %0d", $time, e.solid, a.solid);
            errors++;
        end
        if (a.upd !== e.upd) begin
            $display("%0t: hit_updated expected %0d actual %0d", $time, e.upd, a.upd);
            errors++;
        end
    endfunction
endclass

module tb;
    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic               i_action;
    logic signed [17:0] i_normal_x;
    logic signed [17:0] i_normal_y;
    logic signed [17:0] i_normal_z;
    logic signed [31:0] i_plane_distance;
    logic [15:0]        i_plane_id;
    logic               i_last_side;
    logic               o_valid;
    logic               i_ready;
    logic [16:0]        o_hit_fraction;
    logic [15:0]        o_hit_plane;
    logic               o_starts_out;
    logic               o_all_solid;
    logic               o_hit_updated;

    clip_scoreboard sb;
    bit             quiet;
    bit             started;
    int             stall_count;
    int             span;

    localparam int STALL_LIMIT = 5000;

    segment_convex_brush_clip dut (.*);

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic write_reg(t_clip_reg idx, logic [31:0] v);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.set_reg(idx, v);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    task automatic set_segment(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                               logic [31:0] ex, logic [31:0] ey, logic [31:0] ez,
                               logic [31:0] sw, logic [31:0] ep);
        write_reg(REG_START_X, sx);
        write_reg(REG_START_Y, sy);
        write_reg(REG_START_Z, sz);
        write_reg(REG_END_X, ex);
        write_reg(REG_END_Y, ey);
        write_reg(REG_END_Z, ez);
        write_reg(REG_SWEEP, sw);
        write_reg(REG_EPSILON, ep);
    endtask

    task automatic send_word(t_tb_word w);
        i_valid <= 1;
        i_action <= w.action;
        i_normal_x <= w.nx;
        i_normal_y <= w.ny;
        i_normal_z <= w.nz;
        i_plane_distance <= w.pd;
        i_plane_id <= w.id;
        i_last_side <= w.last;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(w);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    task automatic send_plane(int nx, int ny, int nz, int pd, int id, int last);
        t_tb_word w;
        w.action = ACT_PLANE;
        w.nx = 18'(nx);
        w.ny = 18'(ny);
        w.nz = 18'(nz);
        w.pd = pd;
        w.id = 16'(id);
        w.last = 1'(last);
        send_word(w);
    endtask

    task automatic send_begin();
        t_tb_word w;
        w.action = ACT_BEGIN;
        w.nx = 18'($urandom);
        w.ny = 18'($urandom);
        w.nz = 18'($urandom);
        w.pd = $urandom;
        w.id = 16'($urandom);
        w.last = 1'($urandom);
        send_word(w);
    endtask

    task automatic settle();
        i_valid <= 0;
        while (sb.hits_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic int rand_normal();
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 65536 : -65536;
        return int'($urandom_range(0, 131072)) - 65536;
    endfunction

    function automatic int rand_dist();
        if ($urandom_range(0, 7) == 0) return $urandom;
        return int'($urandom_range(0, span * 2)) - span;
    endfunction

    task automatic random_phase(int count);
        int k;
        int sent;
        sent = 0;
        while (sent < count) begin
            if (count - sent < 150) quiet = 1;
            case ($urandom_range(0, 19))
                0: begin
                    send_begin();
                    sent++;
                end
                1: begin
                    send_plane(rand_normal(), rand_normal(), rand_normal(),
                               $urandom, $urandom, int'($urandom_range(0, 1)));
                    sent++;
                end
                default: begin
                    k = $urandom_range(1, 6);
                    for (int j = 0; j < k; j++) begin
                        send_plane(rand_normal(), rand_normal(), rand_normal(),
                                   rand_dist(), $urandom, int'(j == k - 1));
                    end
                    sent += k;
                end
            endcase
        end
        quiet = 0;
        settle();
    endtask

    initial begin
        sb = new();
        quiet = 0;
        started = 0;
        span = 150 << 16;
        i_rst_n <= 0;
        i_cfg_we <= 0;
        i_cfg_index <= REG_START_X;
        i_cfg_data <= 0;
        i_valid <= 0;
        i_action <= ACT_BEGIN;
        i_normal_x <= 0;
        i_normal_y <= 0;
        i_normal_z <= 0;
        i_plane_distance <= 0;
        i_plane_id <= 0;
        i_last_side <= 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        started = 1;

        // segment at the origin: planes are either on or clear of it
        send_plane(0, 0, 0, 0, 16'h0001, 1);
        send_plane(0, 0, 0, -1, 16'h0002, 1);
        send_begin();
        settle();

        set_segment(-(100 << 16), 0, 0, 100 << 16, 0, 0, 0, 2048);
        send_plane(65536, 0, 0, 50 << 16, 16'hFFFF, 0);
        send_plane(-65536, 0, 0, 60 << 16, 16'h0000, 1);
        send_plane(0, 65536, 0, 10 << 16, 16'h1234, 1);
        send_plane(-65536, 0, 0, -(20 << 16), 16'h0011, 0);
        send_plane(65536, 0, 0, 30 << 16, 16'h0012, 0);
        send_plane(0, 65536, 0, 5 << 16, 16'h0013, 1);
        send_plane(-65536, 0, 0, 200 << 16, 16'h0021, 0);
        send_plane(65536, 0, 0, 200 << 16, 16'h0022, 1);
        send_plane(0, -65536, 0, 32'sh8000_0000, 16'h0031, 1);
        send_plane(0, 0, 65536, 32'sh7FFF_FFFF, 16'h0032, 1);
        send_plane(-65536, 0, 0, 99 << 16, 16'h0041, 1);
        send_plane(-65536, 0, 0, -(200 << 16), 16'h0051, 0);
        send_plane(65536, 0, 0, -(200 << 16), 16'h0052, 1);
        send_begin();
        send_plane(-65536, 0, 0, 0, 16'h0061, 1);
        send_plane(1, 0, 0, 0, 16'h0062, 1);
        settle();

        set_segment(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 65535);
        send_plane(-65536, -65536, -65536, 32'sh8000_0000, 16'hFFFF, 1);
        send_plane(65536, 65536, 65536, 32'sh7FFF_FFFF, 16'h0001, 1);
        send_begin();
        random_phase(200);

        set_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
        span = 32'h7FFF_FFFF;
        random_phase(200);

        span = 150 << 16;
        set_segment(-(100 << 16), 20 << 16, -(7 << 16), 100 << 16, -(30 << 16), 9 << 16,
                    0, 2048);
        random_phase(250);

        set_segment(int'($urandom_range(0, 200 << 16)) - (100 << 16),
                    int'($urandom_range(0, 200 << 16)) - (100 << 16),
                    int'($urandom_range(0, 200 << 16)) - (100 << 16),
                    int'($urandom_range(0, 200 << 16)) - (100 << 16),
                    int'($urandom_range(0, 200 << 16)) - (100 << 16),
                    int'($urandom_range(0, 200 << 16)) - (100 << 16),
                    $urandom_range(0, 8 << 16), $urandom_range(0, 65535));
        random_phase(250);

        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        i_ready <= 0;
        wait (started);
        forever begin
            if (!quiet && $urandom_range(0, 2) == 0) begin
                i_ready <= 0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            i_ready <= 1;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            t_hit_word a;
            a.frac = o_hit_fraction;
            a.plane = o_hit_plane;
            a.so = o_starts_out;
            a.solid = o_all_solid;
            a.upd = o_hit_updated;
            sb.check_hit(a);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end
endmodule
